// File: rtl/core/ctb_pkg.sv
// ----------------------------------------------------------------------------
// Cursor text buffer package
// Field widths, request and status codes, and the per-item control word that
// travels from the decode stage to the memory stage.
// ----------------------------------------------------------------------------
package ctb_pkg;

	localparam int unsigned CTB_CAPACITY = 1024;

	localparam int unsigned REQ_W  = 3;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned POS_W  = 10;
	localparam int unsigned LEN_W  = 11;
	localparam int unsigned STAT_W = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_MOVE_LEFT  = 3'd0,
		REQ_MOVE_RIGHT = 3'd1,
		REQ_BACKSPACE  = 3'd2,
		REQ_INSERT     = 3'd3,
		REQ_READ       = 3'd4
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic {
		SEL_LEFT  = 1'b0,
		SEL_RIGHT = 1'b1
	} store_sel_t;

	typedef struct packed {
		logic       wr_left;
		logic       wr_right;
		logic       src_char;
		logic       is_read;
		store_sel_t rd_sel;
		status_t    status;
	} ctl_t;

endpackage

// File: rtl/core/ctb_ram.sv
// ----------------------------------------------------------------------------
// Cursor text buffer stack memory
// One write port and one read port with registered read data; a read at the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module ctb_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10,
	parameter int unsigned DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/cursor_text_buffer_top.sv
// ----------------------------------------------------------------------------
// Cursor text buffer
// Line-edit buffer kept as two stacks either side of a cursor: move left,
// move right, backspace, insert a byte and read a text position.
// ----------------------------------------------------------------------------
// An item is taken on every clock cycle (busy stays low) and its result shows
// on done after a decode against the stack counts, the registered read of
// the stack memories and the result register. Each stack sits in its own
// one-read one-write memory, so a move, insert or read touches each memory
// at most once and the pipeline never stalls. Results cannot be held off:
// sample them on done.
module cursor_text_buffer_top
	import ctb_pkg::*;
#(
	parameter int unsigned CAPACITY = CTB_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [CHAR_W-1:0] char_in,
	input  logic [POS_W-1:0]  position,
	output logic              done,
	output logic [CHAR_W-1:0] char_out,
	output logic [LEN_W-1:0]  text_length,
	output logic [LEN_W-1:0]  cursor_pos,
	output logic [STAT_W-1:0] status
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

	// decode stage
	logic              valid_s1;
	logic [REQ_W-1:0]  req_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [POS_W-1:0]  pos_s1;

	logic [CW-1:0] lc_q, rc_q;
	logic [CW-1:0] lc_nxt, rc_nxt;

	logic [XW-1:0] lc_x, rc_x, tl_x, pos_x, cap_x;
	ctl_t          ctl_s1;
	logic [AW-1:0] rd_l_addr, rd_r_addr, wr_addr_s1;
	logic          byp_l, byp_r;

	// memory stage
	logic              valid_s2;
	ctl_t              ctl_s2;
	logic [AW-1:0]     wr_addr_s2;
	logic [CHAR_W-1:0] char_s2;
	logic              byp_l_s2, byp_r_s2;
	logic [CHAR_W-1:0] byp_data_s2;
	logic [CHAR_W-1:0] ram_l_rdata, ram_r_rdata;
	logic [CHAR_W-1:0] rd_l_byte, rd_r_byte, rd_byte, wdata_s2;
	logic [CW:0]       tl_now;

	// result register
	logic              done_q;
	logic [CHAR_W-1:0] char_out_q;
	logic [LEN_W-1:0]  len_q, cur_q;
	status_t           status_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1  <= req_type;
			char_s1 <= char_in;
			pos_s1  <= position;
		end
	end

	assign lc_x  = XW'(lc_q);
	assign rc_x  = XW'(rc_q);
	assign tl_x  = lc_x + rc_x;
	assign pos_x = XW'(pos_s1);
	assign cap_x = XW'(CAPACITY);

	always_comb begin
		ctl_s1     = '0;
		ctl_s1.status = ST_DONE;
		rd_l_addr  = '0;
		rd_r_addr  = '0;
		wr_addr_s1 = '0;
		lc_nxt     = lc_q;
		rc_nxt     = rc_q;
		unique case (req_s1)
			REQ_MOVE_LEFT: begin
				if (lc_x != '0 && rc_x < cap_x) begin
					rd_l_addr      = AW'(lc_x - XW'(1));
					wr_addr_s1     = AW'(rc_x);
					ctl_s1.wr_right = 1'b1;
					ctl_s1.rd_sel  = SEL_LEFT;
					lc_nxt         = lc_q - CW'(1);
					rc_nxt         = rc_q + CW'(1);
				end else begin
					ctl_s1.status = ST_IGNORED;
				end
			end
			REQ_MOVE_RIGHT: begin
				if (rc_x != '0 && lc_x < cap_x) begin
					rd_r_addr      = AW'(rc_x - XW'(1));
					wr_addr_s1     = AW'(lc_x);
					ctl_s1.wr_left = 1'b1;
					ctl_s1.rd_sel  = SEL_RIGHT;
					lc_nxt         = lc_q + CW'(1);
					rc_nxt         = rc_q - CW'(1);
				end else begin
					ctl_s1.status = ST_IGNORED;
				end
			end
			REQ_BACKSPACE: begin
				if (lc_x != '0) begin
					lc_nxt = lc_q - CW'(1);
				end else begin
					ctl_s1.status = ST_IGNORED;
				end
			end
			REQ_INSERT: begin
				if (tl_x >= cap_x) begin
					ctl_s1.status = ST_FULL;
				end else begin
					wr_addr_s1      = AW'(lc_x);
					ctl_s1.wr_left  = 1'b1;
					ctl_s1.src_char = 1'b1;
					lc_nxt          = lc_q + CW'(1);
				end
			end
			REQ_READ: begin
				if (pos_x < lc_x) begin
					rd_l_addr      = AW'(pos_x);
					ctl_s1.is_read = 1'b1;
					ctl_s1.rd_sel  = SEL_LEFT;
				end else if (pos_x < tl_x) begin
					// right stack holds text in reverse, top next to the cursor
					rd_r_addr      = AW'(tl_x - XW'(1) - pos_x);
					ctl_s1.is_read = 1'b1;
					ctl_s1.rd_sel  = SEL_RIGHT;
				end else begin
					ctl_s1.status = ST_RANGE;
				end
			end
			default: begin
				ctl_s1.status = ST_IGNORED;
			end
		endcase
	end

	// forward the byte the older item writes this cycle; the memory returns old data
	assign byp_l = valid_s2 && ctl_s2.wr_left  && (wr_addr_s2 == rd_l_addr);
	assign byp_r = valid_s2 && ctl_s2.wr_right && (wr_addr_s2 == rd_r_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q     <= '0;
			rc_q     <= '0;
			valid_s2 <= 1'b0;
			ctl_s2   <= '0;
		end else begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				lc_q   <= lc_nxt;
				rc_q   <= rc_nxt;
				ctl_s2 <= ctl_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s2  <= wr_addr_s1;
		char_s2     <= char_s1;
		byp_l_s2    <= byp_l;
		byp_r_s2    <= byp_r;
		byp_data_s2 <= wdata_s2;
	end

	ctb_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (CHAR_W)
	) u_left_ram (
		.clk   (clk),
		.we    (valid_s2 && ctl_s2.wr_left),
		.waddr (wr_addr_s2),
		.wdata (wdata_s2),
		.raddr (rd_l_addr),
		.rdata (ram_l_rdata)
	);

	ctb_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (CHAR_W)
	) u_right_ram (
		.clk   (clk),
		.we    (valid_s2 && ctl_s2.wr_right),
		.waddr (wr_addr_s2),
		.wdata (wdata_s2),
		.raddr (rd_r_addr),
		.rdata (ram_r_rdata)
	);

	assign rd_l_byte = byp_l_s2 ? byp_data_s2 : ram_l_rdata;
	assign rd_r_byte = byp_r_s2 ? byp_data_s2 : ram_r_rdata;
	assign rd_byte   = (ctl_s2.rd_sel == SEL_LEFT) ? rd_l_byte : rd_r_byte;
	assign wdata_s2  = ctl_s2.src_char ? char_s2 : rd_byte;

	// counts already hold this item's update while it sits in the memory stage
	assign tl_now = {1'b0, lc_q} + {1'b0, rc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			char_out_q <= ctl_s2.is_read ? rd_byte : '0;
			len_q      <= LEN_W'(tl_now);
			cur_q      <= LEN_W'(lc_q);
			status_q   <= ctl_s2.status;
		end
	end

	assign done        = done_q;
	assign char_out    = char_out_q;
	assign text_length = len_q;
	assign cursor_pos  = cur_q;
	assign status      = status_q;

endmodule

// File: rtl/core/ctb_checker.sv
// ----------------------------------------------------------------------------
// Cursor text buffer checker
// Port-level properties of the cursor text buffer, bound to the top level.
// ----------------------------------------------------------------------------
module ctb_checker
	import ctb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [CHAR_W-1:0] char_out,
	input logic [LEN_W-1:0]  text_length,
	input logic [LEN_W-1:0]  cursor_pos,
	input logic [STAT_W-1:0] status
);

	// every accepted item gives its result on done
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("item accepted without a result three cycles later");

	// no result without an item behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without an accepted item");

	a_cursor_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cursor_pos <= text_length))
		else $error("cursor beyond end of text");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_RANGE) |-> (char_out == '0))
		else $error("out-of-range read returned a non-zero byte");

endmodule

bind cursor_text_buffer_top ctb_checker u_ctb_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor text buffer testbench
// Sends cursor moves, backspaces, byte inserts and position reads, one item
// per handshake with random gaps. A two-stack model of the buffer predicts
// every result. Each result is checked field by field against the oldest
// prediction. The stimulus covers the empty text, a short edit script, random
// edits and reads, and a text filled up to capacity.
// ----------------------------------------------------------------------------
module tb_top;
	import ctb_pkg::*;

	localparam int unsigned      CAPACITY       = CTB_CAPACITY;
	localparam logic [REQ_W-1:0] REQ_SPARE_LO   = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI   = 3'd7;
	localparam int unsigned      SETTLE_CYCLES  = 8;
	localparam int unsigned      WATCHDOG_LIMIT = 500;
	localparam int unsigned      PRINT_LIMIT    = 50;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  cursor;
		status_t           st;
	} edit_result_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              start    = 1'b0;
	logic [REQ_W-1:0]  req_type = '0;
	logic [CHAR_W-1:0] char_in  = '0;
	logic [POS_W-1:0]  position = '0;
	logic              busy;
	logic              done;
	logic [CHAR_W-1:0] char_out;
	logic [LEN_W-1:0]  text_length;
	logic [LEN_W-1:0]  cursor_pos;
	logic [STAT_W-1:0] status;

	// model of the two stacks
	logic [CHAR_W-1:0] left_text  [CAPACITY];
	logic [CHAR_W-1:0] right_text [CAPACITY];
	int unsigned       left_len  = 0;
	int unsigned       right_len = 0;

	edit_result_t pending_edits [$];
	int unsigned  error_count = 0;
	int unsigned  idle_cycles = 0;
	bit           steady      = 1'b0;

	cursor_text_buffer_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.char_in     (char_in),
		.position    (position),
		.done        (done),
		.char_out    (char_out),
		.text_length (text_length),
		.cursor_pos  (cursor_pos),
		.status      (status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic edit_result_t apply_edit(input logic [REQ_W-1:0] kind,
			input logic [CHAR_W-1:0] ch, input logic [POS_W-1:0] pos);
		edit_result_t r;
		int unsigned  offset;
		r.ch = '0;
		r.st = ST_DONE;
		case (kind)
			REQ_MOVE_LEFT: begin
				if (left_len > 0 && right_len < CAPACITY) begin
					left_len--;
					right_text[right_len] = left_text[left_len];
					right_len++;
				end else
					r.st = ST_IGNORED;
			end
			REQ_MOVE_RIGHT: begin
				if (right_len > 0 && left_len < CAPACITY) begin
					right_len--;
					left_text[left_len] = right_text[right_len];
					left_len++;
				end else
					r.st = ST_IGNORED;
			end
			REQ_BACKSPACE: begin
				if (left_len > 0)
					left_len--;
				else
					r.st = ST_IGNORED;
			end
			REQ_INSERT: begin
				if (left_len + right_len >= CAPACITY)
					r.st = ST_FULL;
				else begin
					left_text[left_len] = ch;
					left_len++;
				end
			end
			REQ_READ: begin
				if (pos < left_len)
					r.ch = left_text[pos];
				else begin
					offset = pos - left_len;
					// right stack holds the text reversed, top next to the cursor
					if (offset < right_len)
						r.ch = right_text[right_len - 1 - offset];
					else
						r.st = ST_RANGE;
				end
			end
			default: r.st = ST_IGNORED;
		endcase
		r.length = LEN_W'(left_len + right_len);
		r.cursor = LEN_W'(left_len);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("%0t ERROR %s", $time, msg);
		error_count++;
	endtask

	task automatic send_request(input logic [REQ_W-1:0] kind,
			input logic [CHAR_W-1:0] ch, input logic [POS_W-1:0] pos);
		int unsigned gap;
		// now and then switch between back-to-back items and random gaps
		if ($urandom_range(0, 31) == 0)
			steady = ~steady;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		req_type <= kind;
		char_in  <= ch;
		position <= pos;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_edits.push_back(apply_edit(kind, ch, pos));
	endtask

	task automatic send_random_request();
		int unsigned      pick;
		int unsigned      length;
		logic [POS_W-1:0] pos;
		logic [CHAR_W-1:0] ch;
		pick   = $urandom_range(0, 99);
		length = left_len + right_len;
		ch     = CHAR_W'($urandom);
		pos    = POS_W'($urandom);
		// mostly read inside the text, sometimes anywhere
		if (length > 0 && $urandom_range(0, 3) != 0)
			pos = POS_W'($urandom_range(0, length - 1));
		if (pick < 18)
			send_request(REQ_MOVE_LEFT, ch, pos);
		else if (pick < 36)
			send_request(REQ_MOVE_RIGHT, ch, pos);
		else if (pick < 48)
			send_request(REQ_BACKSPACE, ch, pos);
		else if (pick < 76)
			send_request(REQ_INSERT, ch, pos);
		else if (pick < 96)
			send_request(REQ_READ, ch, pos);
		else
			send_request(REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), ch, pos);
	endtask

	task automatic test_empty_text();
		send_request(REQ_MOVE_LEFT, 8'hFF, '1);
		send_request(REQ_MOVE_RIGHT, 8'h00, '0);
		send_request(REQ_BACKSPACE, 8'hFF, '1);
		send_request(REQ_READ, 8'h00, '0);
		send_request(REQ_READ, 8'hFF, '1);
		for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++)
			send_request(REQ_W'(k), CHAR_W'($urandom), POS_W'($urandom));
	endtask

	task automatic test_short_edits();
		send_request(REQ_INSERT, 8'h00, '0);
		send_request(REQ_INSERT, 8'hFF, '1);
		send_request(REQ_INSERT, 8'h55, '0);
		send_request(REQ_INSERT, 8'hAA, '0);
		for (int p = 0; p <= 4; p++)
			send_request(REQ_READ, 8'h00, POS_W'(p));
		send_request(REQ_MOVE_LEFT, 8'h00, '0);
		send_request(REQ_MOVE_LEFT, 8'h00, '0);
		// insert in the middle of the text
		send_request(REQ_INSERT, 8'h3C, '0);
		send_request(REQ_READ, 8'h00, 10'd2);
		send_request(REQ_READ, 8'h00, 10'd3);
		send_request(REQ_MOVE_RIGHT, 8'h00, '0);
		send_request(REQ_MOVE_RIGHT, 8'h00, '0);
		send_request(REQ_MOVE_RIGHT, 8'h00, '0);
		send_request(REQ_BACKSPACE, 8'h00, '0);
		send_request(REQ_BACKSPACE, 8'h00, '0);
		send_request(REQ_READ, 8'h00, 10'h200);
		send_request(REQ_READ, 8'h00, 10'h1FF);
	endtask

	task automatic test_random_edits(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_random_request();
	endtask

	task automatic test_full_text();
		// cursor to the end, then fill so that the whole text sits left of it
		while (right_len > 0)
			send_request(REQ_MOVE_RIGHT, CHAR_W'($urandom), POS_W'($urandom));
		while (left_len + right_len < CAPACITY)
			send_request(REQ_INSERT, CHAR_W'($urandom), POS_W'($urandom));
		send_request(REQ_INSERT, CHAR_W'($urandom), POS_W'($urandom));
		send_request(REQ_MOVE_RIGHT, CHAR_W'($urandom), POS_W'($urandom));
		send_request(REQ_READ, 8'h00, '1);
		repeat ($urandom_range(1, 40))
			send_request(REQ_MOVE_LEFT, CHAR_W'($urandom), POS_W'($urandom));
		send_request(REQ_INSERT, CHAR_W'($urandom), POS_W'($urandom));
		send_request(REQ_READ, 8'h00, '0);
		send_request(REQ_READ, 8'h00, '1);
		send_request(REQ_READ, 8'h00, POS_W'(left_len));
		send_request(REQ_BACKSPACE, CHAR_W'($urandom), POS_W'($urandom));
		send_request(REQ_INSERT, CHAR_W'($urandom), POS_W'($urandom));
		send_request(REQ_INSERT, CHAR_W'($urandom), POS_W'($urandom));
	endtask

	// result checker
	always @(posedge clk) begin
		edit_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_edits.size() == 0)
				report_mismatch("result with no item outstanding");
			else begin
				want = pending_edits.pop_front();
				if (char_out !== want.ch)
					report_mismatch($sformatf("char_out %0h, expected %0h",
						char_out, want.ch));
				if (text_length !== want.length)
					report_mismatch($sformatf("text_length %0d, expected %0d",
						text_length, want.length));
				if (cursor_pos !== want.cursor)
					report_mismatch($sformatf("cursor_pos %0d, expected %0d",
						cursor_pos, want.cursor));
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.st));
			end
		end
	end

	// watchdog: drop the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_text();
		test_short_edits();
		test_random_edits(300);
		test_full_text();
		test_random_edits(150);

		start <= 1'b0;
		while (pending_edits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
